>>> hdl/tcb_pkg.sv
// Shared types, codes and datapath functions of the colour blender.
`timescale 1ns / 1ps
`default_nettype none

package tcb_pkg;

  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned ModeW     = 16;
  localparam int unsigned ChW       = 8;
  localparam int unsigned CovW      = 9;
  localparam int unsigned FacW      = 6;
  localparam int unsigned SumW      = 15;
  localparam int unsigned DvsW      = 7;
  localparam int unsigned NumCh     = 3;
  localparam int unsigned QuoW      = 8;
  localparam int unsigned DivBits   = 2;
  localparam int unsigned DivStages = QuoW / DivBits;
  localparam int unsigned NumStages = 4 + DivStages;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 3'd0,
    CFG_BLEND_COLOR = 3'd1,
    CFG_FOG_COLOR   = 3'd2,
    CFG_FORCE_BLEND = 3'd3,
    CFG_TWO_CYCLE   = 3'd4,
    CFG_FINAL_SEL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    COL_PIX   = 2'd0,
    COL_MEM   = 2'd1,
    COL_BLEND = 2'd2,
    COL_FOG   = 2'd3
  } color_sel_e;

  typedef enum logic [1:0] {
    FA_COV   = 2'd0,
    FA_FOG   = 2'd1,
    FA_SHADE = 2'd2,
    FA_ZERO  = 2'd3
  } fac_a_e;

  typedef enum logic [1:0] {
    FB_INV  = 2'd0,
    FB_MEM  = 2'd1,
    FB_FULL = 2'd2,
    FB_ZERO = 2'd3
  } fac_b_e;

  typedef struct packed {
    logic [ChW-1:0]  pix_r;
    logic [ChW-1:0]  pix_g;
    logic [ChW-1:0]  pix_b;
    logic [ChW-1:0]  pix_a;
    logic [CovW-1:0] coverage_alpha;
    logic [ChW-1:0]  mem_r;
    logic [ChW-1:0]  mem_g;
    logic [ChW-1:0]  mem_b;
    logic [ChW-1:0]  mem_a;
    logic [ChW-1:0]  shd_alpha;
    logic            blend_en;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] out_r;
    logic [ChW-1:0] out_g;
    logic [ChW-1:0] out_b;
    logic [ChW-1:0] out_a;
  } out_item_t;

  typedef struct packed {
    logic [ChW-1:0] r;
    logic [ChW-1:0] g;
    logic [ChW-1:0] b;
    logic [ChW-1:0] a;
  } rgba_t;

  typedef struct packed {
    color_sel_e ca;
    fac_a_e     fa;
    color_sel_e cb;
    fac_b_e     fb;
  } sel_t;

  typedef struct packed {
    logic [FacW-1:0] a;
    logic [FacW-1:0] b;
  } fac_t;

  // one channel of the restoring divider
  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [QuoW-1:0] quo;
  } dq_t;

  function automatic sel_t cycle_sel(logic [ModeW-1:0] mode, logic cyc);
    sel_t s;
    if (cyc) begin
      s.ca = color_sel_e'(mode[13:12]);
      s.fa = fac_a_e'(mode[9:8]);
      s.cb = color_sel_e'(mode[5:4]);
      s.fb = fac_b_e'(mode[1:0]);
    end else begin
      s.ca = color_sel_e'(mode[15:14]);
      s.fa = fac_a_e'(mode[11:10]);
      s.cb = color_sel_e'(mode[7:6]);
      s.fb = fac_b_e'(mode[3:2]);
    end
    return s;
  endfunction

  function automatic rgba_t pick_color(color_sel_e code, rgba_t pix, rgba_t mem,
                                       rgba_t blend, rgba_t fog);
    rgba_t c;
    case (code)
      COL_PIX:   c = pix;
      COL_MEM:   c = mem;
      COL_BLEND: c = blend;
      COL_FOG:   c = fog;
      default:   c = pix;
    endcase
    return c;
  endfunction

  function automatic fac_t factors(fac_a_e fa, fac_b_e fb, logic [CovW-1:0] cov,
                                   logic [ChW-1:0] fog_a, logic [ChW-1:0] shade,
                                   logic [ChW-1:0] mem_a);
    logic [CovW-1:0] raw_a;
    logic [ChW-1:0]  raw_b;
    fac_t            f;
    case (fa)
      FA_COV:   raw_a = cov;
      FA_FOG:   raw_a = {1'b0, fog_a};
      FA_SHADE: raw_a = {1'b0, shade};
      default:  raw_a = '0;
    endcase
    case (fb)
      FB_INV:  raw_b = raw_a[CovW-1] ? '0 : 8'hff - raw_a[ChW-1:0];
      FB_MEM:  raw_b = mem_a;
      FB_FULL: raw_b = 8'hff;
      default: raw_b = '0;
    endcase
    f.a = raw_a[CovW-1:3];
    f.b = {1'b0, raw_b[ChW-1:3]} + 6'd1;
    return f;
  endfunction

  function automatic logic [SumW-1:0] mac(logic [ChW-1:0] x, logic [FacW-1:0] a,
                                          logic [ChW-1:0] y, logic [FacW-1:0] b);
    logic [SumW-1:0] px;
    logic [SumW-1:0] py;
    px = {7'b0, x} * {9'b0, a};
    py = {7'b0, y} * {9'b0, b};
    return px + py;
  endfunction

  // DivBits quotient bits, msb first; hi is the first bit position
  function automatic dq_t div_steps(dq_t din, logic [DvsW-1:0] dvs, logic [2:0] hi);
    dq_t             r;
    logic [SumW-1:0] sh;
    logic [2:0]      k;
    r = din;
    for (int j = 0; j < DivBits; j++) begin
      k  = hi - 3'(j);
      sh = {8'b0, dvs} << k;
      if (r.rem >= sh) begin
        r.rem    = r.rem - sh;
        r.quo[k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/two_cycle_color_blender.sv
// Top level of the colour blender: config registers and datapath pipeline.
// Throughput: one item per cycle while out_ready_i is high. The pipeline has eight stages:
// two select/multiply pairs and four radix-2-bits-per-stage divide stages.
// Each stage holds while its successor is full and stalled, so bubbles are squeezed out.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears all config to zero.
`timescale 1ns / 1ps
`default_nettype none

module two_cycle_color_blender (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  tcb_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output tcb_pkg::out_item_t               out_data_o,
  input  wire                              cfg_we_i,
  input  wire  [tcb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [tcb_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int unsigned NStg = tcb_pkg::NumStages;
  localparam int unsigned DStg = tcb_pkg::DivStages;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tcb_pkg::ModeW-1:0] mode_q;
  logic [tcb_pkg::CfgW-1:0]  blend_q;
  logic [tcb_pkg::CfgW-1:0]  fog_q;
  logic                      force_q;
  logic                      two_q;
  logic                      fsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      blend_q <= '0;
      fog_q   <= '0;
      force_q <= 1'b0;
      two_q   <= 1'b0;
      fsel_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcb_pkg::CFG_MODE:        mode_q  <= cfg_data_i[tcb_pkg::ModeW-1:0];
        tcb_pkg::CFG_BLEND_COLOR: blend_q <= cfg_data_i;
        tcb_pkg::CFG_FOG_COLOR:   fog_q   <= cfg_data_i;
        tcb_pkg::CFG_FORCE_BLEND: force_q <= cfg_data_i[0];
        tcb_pkg::CFG_TWO_CYCLE:   two_q   <= cfg_data_i[0];
        tcb_pkg::CFG_FINAL_SEL:   fsel_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcb_pkg::rgba_t blend_c;
  tcb_pkg::rgba_t fog_c;
  assign blend_c = tcb_pkg::rgba_t'(blend_q);
  assign fog_c   = tcb_pkg::rgba_t'(fog_q);

  // ---------------------------------------------------------------------------
  // Stage types
  // ---------------------------------------------------------------------------
  typedef logic [tcb_pkg::NumCh-1:0][tcb_pkg::ChW-1:0]  rgb_t;   // [2]=r [1]=g [0]=b
  typedef logic [tcb_pkg::NumCh-1:0][tcb_pkg::SumW-1:0] sums_t;

  typedef struct packed {
    tcb_pkg::in_item_t      item;
    rgb_t                   x;
    rgb_t                   y;
    logic [tcb_pkg::FacW-1:0] a;
    logic [tcb_pkg::FacW-1:0] b;
  } s1_t;

  typedef struct packed {
    tcb_pkg::in_item_t item;
    sums_t             sum;
  } s2_t;

  typedef struct packed {
    rgb_t                     x;
    rgb_t                     y;
    logic [tcb_pkg::FacW-1:0] a;
    logic [tcb_pkg::FacW-1:0] b;
    logic                     direct;   // bypass or blending off: dcol is the result
    tcb_pkg::rgba_t           dcol;
    logic [tcb_pkg::ChW-1:0]  pix_a;
  } s3_t;

  typedef struct packed {
    sums_t                    sum;
    logic [tcb_pkg::DvsW-1:0] dvs;
    logic                     alt;      // result taken from alt_rgb, not the quotient
    rgb_t                     alt_rgb;
    logic [tcb_pkg::ChW-1:0]  res_a;
  } s4_t;

  typedef struct packed {
    tcb_pkg::dq_t [tcb_pkg::NumCh-1:0] ch;
    logic [tcb_pkg::DvsW-1:0]          dvs;
    logic                              alt;
    rgb_t                              alt_rgb;
    logic [tcb_pkg::ChW-1:0]           res_a;
  } div_t;

  // ---------------------------------------------------------------------------
  // Handshake: a stage loads when empty or when its successor moves on
  // ---------------------------------------------------------------------------
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] vld_d;
  logic [NStg-1:0] en;

  assign en[NStg-1] = !vld_q[NStg-1] || out_ready_i;
  for (genvar k = 0; k < NStg - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign vld_d = {vld_q[NStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (en & vld_d) | (~en & vld_q);
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NStg-1];

  // ---------------------------------------------------------------------------
  // Stage 1: cycle 0 colour and factor selection
  // ---------------------------------------------------------------------------
  tcb_pkg::rgba_t pix_in;
  tcb_pkg::rgba_t mem_in;
  tcb_pkg::sel_t  sel0;
  tcb_pkg::rgba_t x0;
  tcb_pkg::rgba_t y0;
  tcb_pkg::fac_t  f0;
  s1_t            s1_d;
  s1_t            s1_q;

  always_comb begin
    pix_in  = '{r: in_data_i.pix_r, g: in_data_i.pix_g, b: in_data_i.pix_b,
                a: in_data_i.pix_a};
    mem_in  = '{r: in_data_i.mem_r, g: in_data_i.mem_g, b: in_data_i.mem_b,
                a: in_data_i.mem_a};
    sel0    = tcb_pkg::cycle_sel(mode_q, 1'b0);
    x0      = tcb_pkg::pick_color(sel0.ca, pix_in, mem_in, blend_c, fog_c);
    y0      = tcb_pkg::pick_color(sel0.cb, pix_in, mem_in, blend_c, fog_c);
    f0      = tcb_pkg::factors(sel0.fa, sel0.fb, in_data_i.coverage_alpha,
                               fog_c.a, in_data_i.shd_alpha, in_data_i.mem_a);
    s1_d.item = in_data_i;
    s1_d.x    = {x0.r, x0.g, x0.b};
    s1_d.y    = {y0.r, y0.g, y0.b};
    s1_d.a    = f0.a;
    s1_d.b    = f0.b;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cycle 0 weighted sums
  // ---------------------------------------------------------------------------
  s2_t s2_d;
  s2_t s2_q;

  always_comb begin
    s2_d.item = s1_q.item;
    for (int c = 0; c < tcb_pkg::NumCh; c++) begin
      s2_d.sum[c] = tcb_pkg::mac(s1_q.x[c], s1_q.a, s1_q.y[c], s1_q.b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: final cycle selection. When two_q is set, the pixel colour is the
  // cycle 0 result (bits 12..5 of each sum), alpha kept from the fragment.
  // Opaque bypass and blending-off both resolve here to a direct colour.
  // ---------------------------------------------------------------------------
  tcb_pkg::rgba_t p1;
  tcb_pkg::rgba_t mem2;
  tcb_pkg::sel_t  self;
  tcb_pkg::sel_t  seloff;
  tcb_pkg::rgba_t xf;
  tcb_pkg::rgba_t yf;
  tcb_pkg::rgba_t offc;
  tcb_pkg::fac_t  ff;
  logic           bypass;
  s3_t            s3_d;
  s3_t            s3_q;

  always_comb begin
    mem2 = '{r: s2_q.item.mem_r, g: s2_q.item.mem_g, b: s2_q.item.mem_b,
             a: s2_q.item.mem_a};
    if (two_q) begin
      p1 = '{r: s2_q.sum[2][12:5], g: s2_q.sum[1][12:5], b: s2_q.sum[0][12:5],
             a: s2_q.item.pix_a};
    end else begin
      p1 = '{r: s2_q.item.pix_r, g: s2_q.item.pix_g, b: s2_q.item.pix_b,
             a: s2_q.item.pix_a};
    end
    self   = tcb_pkg::cycle_sel(mode_q, two_q);
    seloff = tcb_pkg::cycle_sel(mode_q, fsel_q);
    xf     = tcb_pkg::pick_color(self.ca, p1, mem2, blend_c, fog_c);
    yf     = tcb_pkg::pick_color(self.cb, p1, mem2, blend_c, fog_c);
    offc   = tcb_pkg::pick_color(seloff.ca, p1, mem2, blend_c, fog_c);
    ff     = tcb_pkg::factors(self.fa, self.fb, s2_q.item.coverage_alpha,
                              fog_c.a, s2_q.item.shd_alpha, s2_q.item.mem_a);
    bypass = (self.fa == tcb_pkg::FA_COV) && (self.fb == tcb_pkg::FB_INV) &&
             (s2_q.item.coverage_alpha >= 9'd255);
    s3_d.x      = {xf.r, xf.g, xf.b};
    s3_d.y      = {yf.r, yf.g, yf.b};
    s3_d.a      = ff.a;
    s3_d.b      = ff.b;
    s3_d.direct = !s2_q.item.blend_en || bypass;
    s3_d.dcol   = s2_q.item.blend_en ? xf : offc;
    s3_d.pix_a  = s2_q.item.pix_a;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_q <= s3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final sums, divisor A+B, and the non-dividing result
  // ---------------------------------------------------------------------------
  s4_t  s4_d;
  s4_t  s4_q;
  rgb_t dcol_rgb;

  always_comb begin
    dcol_rgb  = {s3_q.dcol.r, s3_q.dcol.g, s3_q.dcol.b};
    s4_d.dvs  = {1'b0, s3_q.a} + {1'b0, s3_q.b};
    s4_d.alt  = s3_q.direct || force_q;
    s4_d.res_a = s3_q.direct ? s3_q.dcol.a : s3_q.pix_a;
    for (int c = 0; c < tcb_pkg::NumCh; c++) begin
      s4_d.sum[c]     = tcb_pkg::mac(s3_q.x[c], s3_q.a, s3_q.y[c], s3_q.b);
      s4_d.alt_rgb[c] = s3_q.direct ? dcol_rgb[c] : s4_d.sum[c][12:5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_q <= s4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5..8: restoring divide, two quotient bits per stage. The sum never
  // exceeds 255 * (A+B), so eight quotient bits cover it.
  // ---------------------------------------------------------------------------
  div_t div_in [DStg];
  div_t div_d  [DStg];
  div_t div_q  [DStg];

  always_comb begin
    div_in[0].dvs     = s4_q.dvs;
    div_in[0].alt     = s4_q.alt;
    div_in[0].alt_rgb = s4_q.alt_rgb;
    div_in[0].res_a   = s4_q.res_a;
    for (int c = 0; c < tcb_pkg::NumCh; c++) begin
      div_in[0].ch[c].rem = s4_q.sum[c];
      div_in[0].ch[c].quo = '0;
    end
  end

  for (genvar k = 0; k < DStg; k++) begin : g_div
    localparam logic [2:0] Hi = 3'(tcb_pkg::QuoW - 1 - k * tcb_pkg::DivBits);

    if (k > 0) begin : g_chain
      assign div_in[k] = div_q[k-1];
    end

    always_comb begin
      div_d[k] = div_in[k];
      for (int c = 0; c < tcb_pkg::NumCh; c++) begin
        div_d[k].ch[c] = tcb_pkg::div_steps(div_in[k].ch[c], div_in[k].dvs, Hi);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[4+k]) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: last divide stage is the output register
  // ---------------------------------------------------------------------------
  div_t last;
  assign last = div_q[DStg-1];

  always_comb begin
    out_data_o.out_r = last.alt ? last.alt_rgb[2] : last.ch[2].quo;
    out_data_o.out_g = last.alt ? last.alt_rgb[1] : last.ch[1].quo;
    out_data_o.out_b = last.alt ? last.alt_rgb[0] : last.ch[0].quo;
    out_data_o.out_a = last.res_a;
  end

`ifndef SYNTH
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("pipeline full and stalled but input ready");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item did not enter first stage");

  a_dvs_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (s4_q.dvs != '0))
    else $error("zero divisor in final cycle");

  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NStg-1] && !last.alt) |->
      ((last.ch[0].rem < {8'b0, last.dvs}) && (last.ch[1].rem < {8'b0, last.dvs}) &&
       (last.ch[2].rem < {8'b0, last.dvs})))
    else $error("divide remainder not below divisor");
`endif

endmodule

`default_nettype wire
